[design/tcw_pkg.sv]
// Package for the text console writer: screen geometry, character codes,
// item kinds and the command/status structs between controller and datapath.
// Used by tcw_ctrl, tcw_datapath and text_console_writer; depends on nothing.
package tcw_pkg;

    localparam int ROWS    = 25;
    localparam int COLUMNS = 80;
    localparam int CELLS   = ROWS * COLUMNS;

    // cells that take their byte from the row below during a scroll
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELL_W = $clog2(CELLS);

    localparam int RESET_COL = (1 < COLUMNS) ? 1 : COLUMNS - 1;
    localparam int RESET_ROW = (10 < ROWS) ? 10 : ROWS - 1;

    // external field widths
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_CELL_W = 11;

    localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic load_item;    // latch the accepted beat
        logic exec_read;    // issue the store read for a read item
        logic exec_put;     // write the character and move the cursor
        logic sweep_step;   // one cell of a clearing or scrolling sweep
        logic sweep_clear;  // sweep writes spaces everywhere
        logic load_result;  // fill the output register
    } tcw_cmd_t;

    typedef struct packed {
        logic item_kind;
        logic put_scrolls;
        logic sweep_last;
        logic out_free;
    } tcw_status_t;

endpackage

[design/text_console_writer.sv]
// Top level of the text console writer: stream ports around the controller
// and the datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// A character-cell console of 25 rows by 80 columns. Each input beat is a
// put (tuser 0) or a read of one cell (tuser 1), and gives exactly one result
// beat with the cursor position after the item. A read or a put that does not
// scroll passes the execute and finish states before the next acceptance; a put
// that scrolls adds a sweep over all ROWS*COLUMNS cells and a drain state; in the
// sweep the screen store (one read port, one write port) is walked one cell a
// cycle, moving each row up and blanking the last.
// After reset the store is cleared to spaces, with s_tready low. A new item is
// taken while the previous result is still waiting.
module text_console_writer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_address[18:8], zero[23:19]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_data[7:0], cursor_column[14:8],
                                   // cursor_row[19:15], cursor_cell[30:20], scrolled[31]
);

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;

    logic [tcw_pkg::CHAR_W-1:0]     read_data;
    logic [tcw_pkg::OUT_COL_W-1:0]  cursor_column;
    logic [tcw_pkg::OUT_ROW_W-1:0]  cursor_row;
    logic [tcw_pkg::OUT_CELL_W-1:0] cursor_cell;
    logic                           scrolled;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_kind           (s_tuser),
        .in_char_code      (s_tdata[7:0]),
        .in_cell_address   (s_tdata[18:8]),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_read_data     (read_data),
        .out_cursor_column (cursor_column),
        .out_cursor_row    (cursor_row),
        .out_cursor_cell   (cursor_cell),
        .out_scrolled      (scrolled)
    );

    assign m_tdata = {scrolled, cursor_cell, cursor_row, cursor_column, read_data};

endmodule

[design/tcw_ctrl.sv]
// Controller for the text console writer: sequences reset clearing, item
// execution, scroll sweeps and the result hand-off.
// Depends on tcw_pkg; drives tcw_datapath through tcw_cmd_t.
module tcw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_CLR_DRAIN = 3'd1;
    localparam logic [2:0] ST_IDLE      = 3'd2;
    localparam logic [2:0] ST_EXEC      = 3'd3;
    localparam logic [2:0] ST_SCROLL    = 3'd4;
    localparam logic [2:0] ST_SCR_DRAIN = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_step  = 1'b1;
                cmd.sweep_clear = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_CLR_DRAIN;
                end
            end
            ST_CLR_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.item_kind == tcw_pkg::KIND_READ) begin
                    cmd.exec_read = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.exec_put = 1'b1;
                    state_next   = status.put_scrolls ? ST_SCROLL : ST_FINISH;
                end
            end
            ST_SCROLL: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_SCR_DRAIN;
                end
            end
            ST_SCR_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold here while the previous result is still unclaimed
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_one_store_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.exec_read, cmd.exec_put, cmd.sweep_step}))
        else $error("controller issued overlapping store operations");

    a_scroll_after_put: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL && $past(state_reg) != ST_SCROLL)
        |-> $past(cmd.exec_put) && $past(status.put_scrolls))
        else $error("scroll sweep started without a scrolling put");

    a_result_leaves_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |=> state_reg == ST_IDLE)
        else $error("result loaded without returning to idle");

endmodule

[design/tcw_datapath.sv]
// Datapath for the text console writer: screen store, cursor registers,
// sweep counter with its write stage, and the output register.
// Depends on tcw_pkg; commanded by tcw_ctrl.
module tcw_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tcw_pkg::tcw_cmd_t              cmd,
    output tcw_pkg::tcw_status_t           status,
    input  logic                           in_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]     in_char_code,
    input  logic [tcw_pkg::ADDR_W-1:0]     in_cell_address,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [tcw_pkg::CHAR_W-1:0]     out_read_data,
    output logic [tcw_pkg::OUT_COL_W-1:0]  out_cursor_column,
    output logic [tcw_pkg::OUT_ROW_W-1:0]  out_cursor_row,
    output logic [tcw_pkg::OUT_CELL_W-1:0] out_cursor_cell,
    output logic                           out_scrolled
);

    logic [tcw_pkg::CHAR_W-1:0] mem [tcw_pkg::CELLS];

    // latched item
    logic                        kind_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg;
    logic [tcw_pkg::CELL_W-1:0]  addr_reg;
    logic                        addr_ok_reg;

    logic [tcw_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]   row_reg, row_next;
    logic                        scrolled_reg;

    logic [tcw_pkg::CELL_W-1:0]  idx_reg;
    logic                        wr_valid_reg;
    logic                        wr_blank_reg;
    logic [tcw_pkg::CELL_W-1:0]  wr_addr_reg;

    logic [tcw_pkg::CHAR_W-1:0]  rdata_reg;

    logic                        m_tvalid_reg;
    logic [tcw_pkg::CHAR_W-1:0]  res_data_reg;
    logic [tcw_pkg::COL_W-1:0]   res_col_reg;
    logic [tcw_pkg::ROW_W-1:0]   res_row_reg;
    logic [tcw_pkg::CELL_W-1:0]  res_cell_reg;
    logic                        res_scrolled_reg;

    logic                        is_newline, is_null, wraps, row_last, steps_row;
    logic [tcw_pkg::CELL_W-1:0]  cursor_cell;
    logic                        in_copy;
    logic                        rd_en;
    logic [tcw_pkg::CELL_W-1:0]  rd_addr;
    logic                        we;
    logic [tcw_pkg::CELL_W-1:0]  wa;
    logic [tcw_pkg::CHAR_W-1:0]  wd;
    logic                        put_we;

    assign cursor_cell = tcw_pkg::CELL_W'(int'(row_reg) * tcw_pkg::COLUMNS + int'(col_reg));

    assign is_newline = (char_reg == tcw_pkg::CHAR_NEWLINE);
    assign is_null    = (char_reg == tcw_pkg::CHAR_NULL);
    assign wraps      = !is_newline && !is_null
                        && (int'(col_reg) == tcw_pkg::COLUMNS - 1);
    assign row_last   = (int'(row_reg) == tcw_pkg::ROWS - 1);
    assign steps_row  = is_newline || wraps;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.exec_put) begin
            if (steps_row) begin
                col_next = '0;
                if (!row_last) begin
                    row_next = row_reg + 1'b1;
                end
            end else if (!is_null) begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign put_we  = cmd.exec_put && !is_newline && !is_null;
    assign in_copy = !cmd.sweep_clear && (int'(idx_reg) < tcw_pkg::COPY_CELLS);

    // read port: sweep fetches the cell one row below, a read item its address
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        if (cmd.sweep_step) begin
            rd_en   = in_copy;
            rd_addr = tcw_pkg::CELL_W'(int'(idx_reg) + tcw_pkg::COLUMNS);
        end else if (cmd.exec_read) begin
            rd_en = addr_ok_reg;
        end
    end

    // write port: the sweep write stage and a put never meet
    always_comb begin
        we = 1'b0;
        wa = cursor_cell;
        wd = char_reg;
        if (wr_valid_reg) begin
            we = 1'b1;
            wa = wr_addr_reg;
            wd = wr_blank_reg ? tcw_pkg::CHAR_SPACE : rdata_reg;
        end else if (put_we) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg    <= in_kind;
            char_reg    <= in_char_code;
            addr_reg    <= tcw_pkg::CELL_W'(in_cell_address);
            addr_ok_reg <= (int'(in_cell_address) < tcw_pkg::CELLS);
        end
        wr_addr_reg  <= idx_reg;
        wr_blank_reg <= !in_copy;
        if (cmd.load_result) begin
            res_data_reg     <= (kind_reg == tcw_pkg::KIND_READ && addr_ok_reg)
                                ? rdata_reg : '0;
            res_col_reg      <= col_reg;
            res_row_reg      <= row_reg;
            res_cell_reg     <= cursor_cell;
            res_scrolled_reg <= scrolled_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= tcw_pkg::COL_W'(tcw_pkg::RESET_COL);
            row_reg      <= tcw_pkg::ROW_W'(tcw_pkg::RESET_ROW);
            scrolled_reg <= 1'b0;
            idx_reg      <= '0;
            wr_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.exec_put) begin
                scrolled_reg <= steps_row && row_last;
            end else if (cmd.exec_read) begin
                scrolled_reg <= 1'b0;
            end
            if (cmd.sweep_step) begin
                idx_reg <= status.sweep_last ? '0 : idx_reg + 1'b1;
            end
            wr_valid_reg <= cmd.sweep_step;
            if (cmd.load_result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.item_kind   = kind_reg;
    assign status.put_scrolls = steps_row && row_last;
    assign status.sweep_last  = (int'(idx_reg) == tcw_pkg::CELLS - 1);
    assign status.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid          = m_tvalid_reg;
    assign out_read_data     = res_data_reg;
    assign out_cursor_column = tcw_pkg::OUT_COL_W'(res_col_reg);
    assign out_cursor_row    = tcw_pkg::OUT_ROW_W'(res_row_reg);
    assign out_cursor_cell   = tcw_pkg::OUT_CELL_W'(res_cell_reg);
    assign out_scrolled      = res_scrolled_reg;

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(col_reg) < tcw_pkg::COLUMNS) && (int'(row_reg) < tcw_pkg::ROWS))
        else $error("cursor left the screen");

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_valid_reg && put_we))
        else $error("sweep write and character write in the same cycle");

    a_result_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> !m_tvalid_reg || m_tready)
        else $error("output register overwritten while still held");

endmodule

[tb/text_console_writer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: directed and random put/read beats,
// random idling on both stream sides, and a scoreboard that predicts every result beat.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_tb;

    localparam int SCREEN_ROWS   = tcw_pkg::ROWS;
    localparam int SCREEN_COLS   = tcw_pkg::COLUMNS;
    localparam int SCREEN_CELLS  = SCREEN_ROWS * SCREEN_COLS;
    localparam int SCROLL_CYCLES = SCREEN_CELLS + 1;
    localparam int RANDOM_ITEMS  = 1875;
    localparam int MAX_WAIT      = 13;
    localparam longint CYCLE_LIMIT = 16_000_000;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_cell;
        logic        scrolled;
    } console_result_t;

    class console_scoreboard;
        logic [7:0]      screen [SCREEN_CELLS];
        int unsigned     cur_col;
        int unsigned     cur_row;
        console_result_t cursor_q[$];
        int              errors;
        int              puts;
        int              reads;
        int              scrolls;
        int              checked;

        function new();
            foreach (screen[i]) screen[i] = tcw_pkg::CHAR_SPACE;
            cur_col = (1 < SCREEN_COLS) ? 1 : SCREEN_COLS - 1;
            cur_row = (10 < SCREEN_ROWS) ? 10 : SCREEN_ROWS - 1;
            errors  = 0;
            puts    = 0;
            reads   = 0;
            scrolls = 0;
            checked = 0;
        endfunction

        // move down one row; scroll the screen when the bottom is passed
        function bit next_line();
            int i;
            cur_row++;
            if (cur_row < SCREEN_ROWS)
                return 1'b0;
            for (i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
                screen[i] = screen[i + SCREEN_COLS];
            for (i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_CELLS; i++)
                screen[i] = tcw_pkg::CHAR_SPACE;
            cur_row = SCREEN_ROWS - 1;
            scrolls++;
            return 1'b1;
        endfunction

        function void note_item(logic kind, logic [7:0] code, logic [10:0] addr);
            console_result_t res;
            int unsigned     cell_idx;
            res = '0;
            if (kind == tcw_pkg::KIND_READ) begin
                reads++;
                if (addr < SCREEN_CELLS)
                    res.read_data = screen[addr];
            end else begin
                puts++;
                if (code == tcw_pkg::CHAR_NEWLINE) begin
                    cur_col = 0;
                    res.scrolled = next_line();
                end else if (code != tcw_pkg::CHAR_NULL) begin
                    screen[cur_row * SCREEN_COLS + cur_col] = code;
                    cur_col++;
                    if (cur_col >= SCREEN_COLS) begin
                        cur_col = 0;
                        res.scrolled = next_line();
                    end
                end
            end
            cell_idx = cur_row * SCREEN_COLS + cur_col;
            res.cursor_column = cur_col[6:0];
            res.cursor_row    = cur_row[4:0];
            res.cursor_cell   = cell_idx[10:0];
            cursor_q.push_back(res);
        endfunction

        function int pending();
            return cursor_q.size();
        endfunction

        task report_mismatch(string field, int got, int want);
            $display("%0t ns: beat %0d %s got %0d want %0d", $time, checked, field, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] beat);
            console_result_t res;
            if (cursor_q.size() == 0) begin
                report_mismatch("unexpected beat, tdata", int'(beat), 0);
                return;
            end
            res = cursor_q.pop_front();
            if (beat[7:0] !== res.read_data)
                report_mismatch("read_data", int'(beat[7:0]), int'(res.read_data));
            if (beat[14:8] !== res.cursor_column)
                report_mismatch("cursor_column", int'(beat[14:8]),
                                int'(res.cursor_column));
            if (beat[19:15] !== res.cursor_row)
                report_mismatch("cursor_row", int'(beat[19:15]), int'(res.cursor_row));
            if (beat[30:20] !== res.cursor_cell)
                report_mismatch("cursor_cell", int'(beat[30:20]), int'(res.cursor_cell));
            if (beat[31] !== res.scrolled)
                report_mismatch("scrolled", int'(beat[31]), int'(res.scrolled));
            checked++;
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // char_code[7:0], cell_address[18:8], zero[23:19]
    logic        s_tuser  = 1'b0; // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // read_data, cursor_column, cursor_row, cursor_cell, scrolled

    console_scoreboard sb = new();
    bit     no_idle = 1'b0;
    longint cycles  = 0;

    text_console_writer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: take a beat, then hold tready low for a drawn number of cycles
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
                if (stall > 0)
                    m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (stall > 0)
                    stall--;
                else
                    m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] code,
                             input logic [10:0] addr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, addr, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(kind, code, addr);
    endtask

    task automatic drain_results();
        do @(posedge aclk); while (sb.pending() > 0);
    endtask

    initial begin
        int          i;
        int          pick;
        logic        kind;
        logic [7:0]  code;
        logic [10:0] addr;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // cleared screen, edges of the address range and out-of-screen reads
        send_item(tcw_pkg::KIND_READ, 8'h00, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'hff, 11'd2047);
        send_item(tcw_pkg::KIND_READ, 8'h00, 11'd2000);
        send_item(tcw_pkg::KIND_READ, 8'h00, 11'd1999);
        // plain puts, a null that must leave everything alone, extreme bytes
        send_item(tcw_pkg::KIND_PUT, 8'h41, 11'd0);
        send_item(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_NULL, 11'h7ff);
        send_item(tcw_pkg::KIND_PUT, 8'hff, 11'd0);
        send_item(tcw_pkg::KIND_PUT, 8'h7f, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'h00, 11'd801);
        send_item(tcw_pkg::KIND_READ, 8'h00, 11'd802);
        // newlines down to the bottom and one past it, which scrolls
        for (i = 0; i < SCREEN_ROWS - 10; i++)
            send_item(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_NEWLINE, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'h00, 11'd721);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 300 == 150)
                no_idle = 1'b1;
            else if (i % 300 == 220)
                no_idle = 1'b0;
            if (i == RANDOM_ITEMS / 2) begin
                // hold the sender until every result is back
                s_tvalid <= 1'b0;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            code = 8'($urandom_range(8'h21, 8'h7e));
            addr = 11'($urandom_range(0, 2047));
            if (pick < 25) begin
                kind = tcw_pkg::KIND_READ;
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    addr = 11'($urandom_range(0, SCREEN_CELLS - 1));
                else if (pick < 85)
                    addr = 11'($urandom_range((SCREEN_ROWS - 5) * SCREEN_COLS,
                                              SCREEN_CELLS - 1));
                else
                    addr = 11'($urandom_range(SCREEN_CELLS, 2047));
            end else begin
                kind = tcw_pkg::KIND_PUT;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    code = tcw_pkg::CHAR_NEWLINE;
                else if (pick < 6)
                    code = tcw_pkg::CHAR_NULL;
                else if (pick < 18)
                    code = 8'($urandom_range(0, 255));
            end
            send_item(kind, code, addr);
        end

        s_tvalid <= 1'b0;
        drain_results();
        repeat (SCROLL_CYCLES + 16) @(posedge aclk);

        $display("run covered %0d puts and %0d reads, %0d of them scrolling the screen;",
                 sb.puts, sb.reads, sb.scrolls);
        $display("%0d result beats checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
